/* hw/rtl/sct_pkg.sv */
// Shared types, token kind codes, scan modes and helper functions for the
// source code tokenizer. No dependencies.
package sct_pkg;

    localparam int OFF_W         = 24;
    localparam int LINE_W        = 20;
    localparam int KEYWORD_CHARS = 7;
    localparam int KW_W          = 8 * KEYWORD_CHARS;
    localparam int KW_LEN_W      = $clog2(KEYWORD_CHARS + 2);
    localparam int KIND_W        = 7;
    localparam int CAUSE_W       = 3;
    localparam int TOK_PER_BUNDLE = 3;
    localparam int SCT_QUEUE_DEPTH = 4;

    localparam logic [OFF_W-1:0]  OFF_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // Token kinds
    localparam logic [KIND_W-1:0] K_EOF        = 7'd0;
    localparam logic [KIND_W-1:0] K_ERROR      = 7'd1;
    localparam logic [KIND_W-1:0] K_IDENT      = 7'd2;
    localparam logic [KIND_W-1:0] K_KW_FIRST   = 7'd3;
    localparam logic [KIND_W-1:0] K_MATCH      = 7'd38;
    localparam logic [KIND_W-1:0] K_NUMBER     = 7'd49;
    localparam logic [KIND_W-1:0] K_STRING     = 7'd50;
    localparam logic [KIND_W-1:0] K_REGEX      = 7'd51;
    localparam logic [KIND_W-1:0] K_LPAREN     = 7'd52;
    localparam logic [KIND_W-1:0] K_RPAREN     = 7'd53;
    localparam logic [KIND_W-1:0] K_LBRACE     = 7'd54;
    localparam logic [KIND_W-1:0] K_RBRACE     = 7'd55;
    localparam logic [KIND_W-1:0] K_LBRACKET   = 7'd56;
    localparam logic [KIND_W-1:0] K_RBRACKET   = 7'd57;
    localparam logic [KIND_W-1:0] K_SEMI       = 7'd58;
    localparam logic [KIND_W-1:0] K_COMMA      = 7'd59;
    localparam logic [KIND_W-1:0] K_QQ         = 7'd60;
    localparam logic [KIND_W-1:0] K_QDOT       = 7'd61;
    localparam logic [KIND_W-1:0] K_QUESTION   = 7'd62;
    localparam logic [KIND_W-1:0] K_COLON      = 7'd63;
    localparam logic [KIND_W-1:0] K_AT         = 7'd64;
    localparam logic [KIND_W-1:0] K_HASH       = 7'd65;
    localparam logic [KIND_W-1:0] K_DOT        = 7'd66;
    localparam logic [KIND_W-1:0] K_MINUS      = 7'd67;
    localparam logic [KIND_W-1:0] K_EQUAL      = 7'd68;
    localparam logic [KIND_W-1:0] K_BANG       = 7'd69;
    localparam logic [KIND_W-1:0] K_AMP        = 7'd70;
    localparam logic [KIND_W-1:0] K_PIPE       = 7'd71;
    localparam logic [KIND_W-1:0] K_SLASH      = 7'd72;
    localparam logic [KIND_W-1:0] K_PERCENT    = 7'd73;
    localparam logic [KIND_W-1:0] K_STAR       = 7'd74;
    localparam logic [KIND_W-1:0] K_CARET_PLUS = 7'd75;
    localparam logic [KIND_W-1:0] K_CARET      = 7'd76;
    localparam logic [KIND_W-1:0] K_TILDE      = 7'd77;
    localparam logic [KIND_W-1:0] K_PLUS_TILDE = 7'd78;
    localparam logic [KIND_W-1:0] K_PLUS       = 7'd79;
    localparam logic [KIND_W-1:0] K_BANG_EQ    = 7'd80;
    localparam logic [KIND_W-1:0] K_EQ_EQ      = 7'd81;
    localparam logic [KIND_W-1:0] K_LESS_EQ    = 7'd82;
    localparam logic [KIND_W-1:0] K_LESS       = 7'd83;
    localparam logic [KIND_W-1:0] K_GREATER_EQ = 7'd84;
    localparam logic [KIND_W-1:0] K_GREATER    = 7'd85;
    localparam logic [KIND_W-1:0] K_PIPE_GT    = 7'd86;
    localparam logic [KIND_W-1:0] K_PIPE_Q     = 7'd87;

    // Error causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_UNEXPECTED = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_OPEN_STR  = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_OPEN_RE   = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_LONE_AMP  = 3'd4;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_LCOM, M_BLOCK, M_BSTAR, M_IDENT, M_NUM, M_NUMDOT,
        M_FRAC, M_STR, M_RE, M_REESC, M_QUEST, M_CARET, M_PLUSOP, M_BANGOP,
        M_EQOP, M_LTOP, M_GTOP, M_AMPOP, M_PIPEOP
    } mode_t;

    typedef logic [KW_W-1:0] kw_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CAUSE_W-1:0] cause;
        logic [OFF_W-1:0]   start;
        logic [OFF_W-1:0]   len;
        logic [LINE_W-1:0]  line;
    } tok_t;

    typedef struct packed {
        logic [1:0]                   cnt;
        tok_t [TOK_PER_BUNDLE-1:0]    tok;
    } bundle_t;

    // Keywords, first character in the highest used byte; kind = K_KW_FIRST + index
    localparam int KW_COUNT = 46;
    localparam kw_word_t KW_WORDS [KW_COUNT] = '{
        kw_word_t'("v"), kw_word_t'("c"), kw_word_t'("r"), kw_word_t'("i"),
        kw_word_t'("e"), kw_word_t'("f"), kw_word_t'("w"), kw_word_t'("l"),
        kw_word_t'("m"), kw_word_t'("b"), kw_word_t'("s"), kw_word_t'("as"),
        kw_word_t'("fn"), kw_word_t'("ei"), kw_word_t'("st"), kw_word_t'("en"),
        kw_word_t'("tr"), kw_word_t'("tp"), kw_word_t'("in"), kw_word_t'("u8"),
        kw_word_t'("pr"), kw_word_t'("db"), kw_word_t'("ret"), kw_word_t'("any"),
        kw_word_t'("async"), kw_word_t'("await"), kw_word_t'("clone"),
        kw_word_t'("else"), kw_word_t'("eval"), kw_word_t'("false"),
        kw_word_t'("has"), kw_word_t'("impl"), kw_word_t'("json"),
        kw_word_t'("keys"), kw_word_t'("mut"), kw_word_t'("match"),
        kw_word_t'("nil"), kw_word_t'("pub"), kw_word_t'("panic"),
        kw_word_t'("recover"), kw_word_t'("spawn"), kw_word_t'("sync"),
        kw_word_t'("try"), kw_word_t'("true"), kw_word_t'("typeof"),
        kw_word_t'("use")
    };

    // Kind of a finished identifier
    function automatic logic [KIND_W-1:0] ident_kind(input kw_word_t chars,
                                                     input logic [KW_LEN_W-1:0] len);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        if (len <= KW_LEN_W'(KEYWORD_CHARS))
        begin
            for (int i = 0; i < KW_COUNT; i++)
            begin
                if (chars == KW_WORDS[i])
                begin
                    k = K_KW_FIRST + KIND_W'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic logic regex_allowed(input logic [KIND_W-1:0] p);
        return p == K_EQUAL || p == K_LPAREN || p == K_COMMA || p == K_COLON ||
               p == K_BANG || p == K_AMP || p == K_PIPE || p == K_EOF ||
               p == K_MATCH;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] v);
        return (v == OFF_MAX) ? v : v + OFF_W'(1);
    endfunction

    function automatic tok_t make_tok(input logic [KIND_W-1:0] kind,
                                      input logic [CAUSE_W-1:0] cause,
                                      input logic [OFF_W-1:0] start,
                                      input logic [OFF_W-1:0] stop,
                                      input logic [LINE_W-1:0] line);
        tok_t t;
        t.kind  = kind;
        t.cause = cause;
        t.start = start;
        t.len   = stop - start;
        t.line  = line;
        return t;
    endfunction

endpackage

/* hw/rtl/sct_lexer.sv */
// Front part: accepts source bytes, runs the scanner state and builds a
// bundle of up to three tokens per byte. Depends on sct_pkg.
module sct_lexer
    import sct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       is_end,
    input  logic       q_full,
    output logic       push,
    output bundle_t    push_bundle
);

    mode_t                mode_reg, mode_next;
    logic [OFF_W-1:0]     ls_reg, ls_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [KIND_W-1:0]    prev_reg, prev_next;
    kw_word_t             kw_reg, kw_next;
    logic [KW_LEN_W-1:0]  kwlen_reg, kwlen_next;
    logic [7:0]           pb_reg;
    logic                 fin_reg, fin_next;

    logic                 accept;
    tok_t                 tok_v [TOK_PER_BUNDLE];
    logic [1:0]           n;
    logic                 do_idle;
    logic [OFF_W-1:0]     base, base_p1, off_p1, off_p2;
    logic [KIND_W-1:0]    two, single, idk;
    logic                 two_hit;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign off_p1   = off_inc(off_reg);
    assign off_p2   = off_inc(off_p1);
    assign idk      = ident_kind(kw_reg, kwlen_reg);

    // Two-char operator completion and single-char fallback of a pending operator
    always_comb
    begin
        two    = K_EOF;
        two_hit = 1'b0;
        single = K_PIPE;
        unique case (mode_reg)
            M_QUEST:
            begin
                single = K_QUESTION;
                if (ch == "?") begin two = K_QQ; two_hit = 1'b1; end
                else if (ch == ".") begin two = K_QDOT; two_hit = 1'b1; end
            end
            M_CARET:
            begin
                single = K_CARET;
                if (ch == "+") begin two = K_CARET_PLUS; two_hit = 1'b1; end
            end
            M_PLUSOP:
            begin
                single = K_PLUS;
                if (ch == "~") begin two = K_PLUS_TILDE; two_hit = 1'b1; end
            end
            M_BANGOP:
            begin
                single = K_BANG;
                if (ch == "=") begin two = K_BANG_EQ; two_hit = 1'b1; end
            end
            M_EQOP:
            begin
                single = K_EQUAL;
                if (ch == "=") begin two = K_EQ_EQ; two_hit = 1'b1; end
            end
            M_LTOP:
            begin
                single = K_LESS;
                if (ch == "=") begin two = K_LESS_EQ; two_hit = 1'b1; end
            end
            M_GTOP:
            begin
                single = K_GREATER;
                if (ch == "=") begin two = K_GREATER_EQ; two_hit = 1'b1; end
            end
            M_AMPOP:
            begin
                single = K_ERROR;
                if (ch == "&") begin two = K_AMP; two_hit = 1'b1; end
            end
            M_PIPEOP:
            begin
                single = K_PIPE;
                if (ch == ">") begin two = K_PIPE_GT; two_hit = 1'b1; end
                else if (ch == "?") begin two = K_PIPE_Q; two_hit = 1'b1; end
                else if (ch == "|") begin two = K_PIPE; two_hit = 1'b1; end
            end
            default:
            begin
                single = K_PIPE;
            end
        endcase
    end

    // Scanner step: end-of-text flush, or pending token(s) then the byte from idle
    always_comb
    begin
        for (int i = 0; i < TOK_PER_BUNDLE; i++)
        begin
            tok_v[i] = '0;
        end
        n          = 2'd0;
        do_idle    = 1'b0;
        base       = off_reg;
        base_p1    = off_p1;
        mode_next  = mode_reg;
        ls_next    = ls_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        prev_next  = prev_reg;
        kw_next    = kw_reg;
        kwlen_next = kwlen_reg;
        fin_next   = fin_reg;

        if (!fin_reg && (is_end || ch == 8'd0))
        begin
            // Flush the pending lexeme, then EOF
            unique case (mode_reg)
                M_SLASH:
                begin
                    if (regex_allowed(prev_reg))
                    begin
                        tok_v[n] = make_tok(K_ERROR, CAUSE_OPEN_RE, ls_reg, off_reg, line_reg);
                    end
                    else
                    begin
                        tok_v[n] = make_tok(K_SLASH, CAUSE_NONE, ls_reg, off_reg, line_reg);
                    end
                    n = n + 2'd1;
                end
                M_IDENT:
                begin
                    tok_v[n] = make_tok(idk, CAUSE_NONE, ls_reg, off_reg, line_reg);
                    n = n + 2'd1;
                end
                M_NUM, M_FRAC:
                begin
                    tok_v[n] = make_tok(K_NUMBER, CAUSE_NONE, ls_reg, off_reg, line_reg);
                    n = n + 2'd1;
                end
                M_NUMDOT:
                begin
                    tok_v[n] = make_tok(K_NUMBER, CAUSE_NONE, ls_reg, off_reg, line_reg);
                    n = n + 2'd1;
                    tok_v[n] = make_tok(K_DOT, CAUSE_NONE, off_reg, off_p1, line_reg);
                    n = n + 2'd1;
                    off_next = off_p1;
                end
                M_STR:
                begin
                    tok_v[n] = make_tok(K_ERROR, CAUSE_OPEN_STR, ls_reg, off_reg, line_reg);
                    n = n + 2'd1;
                end
                M_RE, M_REESC:
                begin
                    tok_v[n] = make_tok(K_ERROR, CAUSE_OPEN_RE, ls_reg, off_reg, line_reg);
                    n = n + 2'd1;
                end
                M_QUEST, M_CARET, M_PLUSOP, M_BANGOP, M_EQOP, M_LTOP, M_GTOP,
                M_AMPOP, M_PIPEOP:
                begin
                    tok_v[n] = make_tok(single,
                                        (mode_reg == M_AMPOP) ? CAUSE_LONE_AMP : CAUSE_NONE,
                                        ls_reg, off_reg, line_reg);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            tok_v[n]  = make_tok(K_EOF, CAUSE_NONE, off_next, off_next, line_reg);
            n         = n + 2'd1;
            mode_next = M_IDLE;
            ls_next   = off_next;
            prev_next = K_EOF;
            fin_next  = 1'b1;
        end
        else if (!fin_reg)
        begin
            if (ch == 8'h0a && line_reg != LINE_MAX)
            begin
                line_next = line_reg + LINE_W'(1);
            end
            unique case (mode_reg)
                M_IDLE:
                begin
                    do_idle = 1'b1;
                end
                M_SLASH:
                begin
                    if (ch == "/")
                    begin
                        off_next  = off_p1;
                        mode_next = M_LCOM;
                    end
                    else if (ch == "*")
                    begin
                        off_next  = off_p1;
                        mode_next = M_BLOCK;
                    end
                    else if (regex_allowed(prev_reg))
                    begin
                        off_next  = off_p1;
                        mode_next = (ch == "\\") ? M_REESC : M_RE;
                    end
                    else
                    begin
                        tok_v[n] = make_tok(K_SLASH, CAUSE_NONE, ls_reg, off_reg, line_reg);
                        n = n + 2'd1;
                        prev_next = K_SLASH;
                        do_idle = 1'b1;
                    end
                end
                M_LCOM:
                begin
                    if (ch == 8'h0a)
                    begin
                        do_idle = 1'b1;
                    end
                    else
                    begin
                        off_next = off_p1;
                    end
                end
                M_BLOCK:
                begin
                    off_next = off_p1;
                    if (ch == "*")
                    begin
                        mode_next = M_BSTAR;
                    end
                end
                M_BSTAR:
                begin
                    off_next = off_p1;
                    if (ch == "/")
                    begin
                        mode_next = M_IDLE;
                    end
                    else if (ch != "*")
                    begin
                        mode_next = M_BLOCK;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(ch) || is_digit(ch))
                    begin
                        off_next = off_p1;
                        if (kwlen_reg < KW_LEN_W'(KEYWORD_CHARS))
                        begin
                            kw_next = {kw_reg[KW_W-9:0], ch};
                        end
                        if (kwlen_reg <= KW_LEN_W'(KEYWORD_CHARS))
                        begin
                            kwlen_next = kwlen_reg + KW_LEN_W'(1);
                        end
                    end
                    else
                    begin
                        tok_v[n] = make_tok(idk, CAUSE_NONE, ls_reg, off_reg, line_reg);
                        n = n + 2'd1;
                        prev_next = idk;
                        do_idle = 1'b1;
                    end
                end
                M_NUM, M_FRAC:
                begin
                    if (is_digit(ch))
                    begin
                        off_next = off_p1;
                    end
                    else if (ch == "." && mode_reg == M_NUM)
                    begin
                        mode_next = M_NUMDOT;
                    end
                    else
                    begin
                        tok_v[n] = make_tok(K_NUMBER, CAUSE_NONE, ls_reg, off_reg, line_reg);
                        n = n + 2'd1;
                        prev_next = K_NUMBER;
                        do_idle = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(ch))
                    begin
                        off_next  = off_p2;
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        tok_v[n] = make_tok(K_NUMBER, CAUSE_NONE, ls_reg, off_reg, line_reg);
                        n = n + 2'd1;
                        tok_v[n] = make_tok(K_DOT, CAUSE_NONE, off_reg, off_p1, line_reg);
                        n = n + 2'd1;
                        prev_next = K_DOT;
                        base      = off_p1;
                        base_p1   = off_p2;
                        do_idle   = 1'b1;
                    end
                end
                M_STR:
                begin
                    off_next = off_p1;
                    if (ch == "\"" && pb_reg != "\\")
                    begin
                        tok_v[n] = make_tok(K_STRING, CAUSE_NONE, ls_reg, off_p1, line_reg);
                        n = n + 2'd1;
                        prev_next = K_STRING;
                        mode_next = M_IDLE;
                    end
                end
                M_RE:
                begin
                    off_next = off_p1;
                    if (ch == "/")
                    begin
                        tok_v[n] = make_tok(K_REGEX, CAUSE_NONE, ls_reg, off_p1, line_reg);
                        n = n + 2'd1;
                        prev_next = K_REGEX;
                        mode_next = M_IDLE;
                    end
                    else if (ch == "\\")
                    begin
                        mode_next = M_REESC;
                    end
                end
                M_REESC:
                begin
                    off_next  = off_p1;
                    mode_next = M_RE;
                end
                M_QUEST, M_CARET, M_PLUSOP, M_BANGOP, M_EQOP, M_LTOP, M_GTOP,
                M_AMPOP, M_PIPEOP:
                begin
                    if (two_hit)
                    begin
                        tok_v[n] = make_tok(two, CAUSE_NONE, ls_reg, off_p1, line_reg);
                        n = n + 2'd1;
                        prev_next = two;
                        off_next  = off_p1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        tok_v[n] = make_tok(single,
                                            (mode_reg == M_AMPOP) ? CAUSE_LONE_AMP : CAUSE_NONE,
                                            ls_reg, off_reg, line_reg);
                        n = n + 2'd1;
                        prev_next = single;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // Byte seen from the idle state: start a lexeme here
            if (do_idle)
            begin
                ls_next   = base;
                off_next  = base_p1;
                mode_next = M_IDLE;
                if (ch == " " || ch == 8'h0d || ch == 8'h09 || ch == 8'h0a)
                begin
                    mode_next = M_IDLE;
                end
                else if (is_alpha(ch))
                begin
                    kw_next    = kw_word_t'(ch);
                    kwlen_next = KW_LEN_W'(1);
                    mode_next  = M_IDENT;
                end
                else if (is_digit(ch))
                begin
                    mode_next = M_NUM;
                end
                else
                begin
                    unique case (ch)
                        "(", ")", "{", "}", "[", "]", ";", ",", ":", "@", "#", ".",
                        "-", "%", "*", "~":
                        begin
                            unique case (ch)
                                "(": tok_v[n] = make_tok(K_LPAREN, CAUSE_NONE, base, base_p1, line_reg);
                                ")": tok_v[n] = make_tok(K_RPAREN, CAUSE_NONE, base, base_p1, line_reg);
                                "{": tok_v[n] = make_tok(K_LBRACE, CAUSE_NONE, base, base_p1, line_reg);
                                "}": tok_v[n] = make_tok(K_RBRACE, CAUSE_NONE, base, base_p1, line_reg);
                                "[": tok_v[n] = make_tok(K_LBRACKET, CAUSE_NONE, base, base_p1, line_reg);
                                "]": tok_v[n] = make_tok(K_RBRACKET, CAUSE_NONE, base, base_p1, line_reg);
                                ";": tok_v[n] = make_tok(K_SEMI, CAUSE_NONE, base, base_p1, line_reg);
                                ",": tok_v[n] = make_tok(K_COMMA, CAUSE_NONE, base, base_p1, line_reg);
                                ":": tok_v[n] = make_tok(K_COLON, CAUSE_NONE, base, base_p1, line_reg);
                                "@": tok_v[n] = make_tok(K_AT, CAUSE_NONE, base, base_p1, line_reg);
                                "#": tok_v[n] = make_tok(K_HASH, CAUSE_NONE, base, base_p1, line_reg);
                                ".": tok_v[n] = make_tok(K_DOT, CAUSE_NONE, base, base_p1, line_reg);
                                "-": tok_v[n] = make_tok(K_MINUS, CAUSE_NONE, base, base_p1, line_reg);
                                "%": tok_v[n] = make_tok(K_PERCENT, CAUSE_NONE, base, base_p1, line_reg);
                                "*": tok_v[n] = make_tok(K_STAR, CAUSE_NONE, base, base_p1, line_reg);
                                default: tok_v[n] = make_tok(K_TILDE, CAUSE_NONE, base, base_p1, line_reg);
                            endcase
                            prev_next = tok_v[n].kind;
                            n = n + 2'd1;
                        end
                        "/": mode_next = M_SLASH;
                        "\"": mode_next = M_STR;
                        "?": mode_next = M_QUEST;
                        "^": mode_next = M_CARET;
                        "+": mode_next = M_PLUSOP;
                        "!": mode_next = M_BANGOP;
                        "=": mode_next = M_EQOP;
                        "<": mode_next = M_LTOP;
                        ">": mode_next = M_GTOP;
                        "&": mode_next = M_AMPOP;
                        "|": mode_next = M_PIPEOP;
                        default:
                        begin
                            tok_v[n] = make_tok(K_ERROR, CAUSE_UNEXPECTED, base, base_p1, line_reg);
                            n = n + 2'd1;
                        end
                    endcase
                end
            end
        end
    end

    // Hand the bundle to the queue
    always_comb
    begin
        push_bundle.cnt = n;
        for (int i = 0; i < TOK_PER_BUNDLE; i++)
        begin
            push_bundle.tok[i] = tok_v[i];
        end
    end
    assign push = accept && (n != 2'd0);

    // Advance scanner state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            ls_reg    <= '0;
            off_reg   <= '0;
            line_reg  <= LINE_W'(1);
            prev_reg  <= K_EOF;
            kw_reg    <= '0;
            kwlen_reg <= '0;
            pb_reg    <= '0;
            fin_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            ls_reg    <= ls_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            prev_reg  <= prev_next;
            kw_reg    <= kw_next;
            kwlen_reg <= kwlen_next;
            pb_reg    <= ch;
            fin_reg   <= fin_next;
        end
    end

endmodule

/* hw/rtl/sct_queue.sv */
// Short queue of token bundles between the scanner and the token sender.
// Depends on sct_pkg.
module sct_queue
    import sct_pkg::*;
#(
    parameter int DEPTH = SCT_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_bundle,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rd_reg];

    // Store a bundle at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_bundle;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count did not advance");
`endif

endmodule

/* hw/rtl/sct_emitter.sv */
// Back part: takes bundles from the queue and sends their tokens one per
// ready cycle, marking the last token of each bundle. Depends on sct_pkg.
module sct_emitter
    import sct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_not_empty,
    input  bundle_t q_head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output tok_t    out_tok,
    output logic    out_last
);

    bundle_t    cur_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       fire;

    assign out_valid = valid_reg;
    assign out_tok   = cur_reg.tok[idx_reg];
    assign out_last  = idx_reg == (cur_reg.cnt - 2'd1);
    assign fire      = valid_reg && out_ready;
    assign pop       = q_not_empty && (!valid_reg || (fire && out_last));

    // Load the next bundle or step to the next token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            if (out_last)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold the bundle payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_head;
        end
    end

endmodule

/* hw/rtl/source_code_tokenizer_top.sv */
// Source code tokenizer: top level joining scanner, bundle queue and sender.
// Depends on sct_pkg, sct_lexer, sct_queue, sct_emitter.
//
// Input stream: one source byte per request on s_tdata; s_tlast marks end of
// text (byte ignored). A zero byte also ends the text. After the end, the
// pending lexeme is flushed, an EOF token is sent, and later requests are
// taken and dropped until reset.
// Output stream: one token per request; m_tuser carries kind and error cause,
// m_tdata the start offset, length and line; m_tlast marks the final token
// caused by one input byte.
// Throughput: one byte per cycle in, one token per cycle out. A byte may
// yield up to three tokens; the bundle queue (QUEUE_DEPTH bundles) absorbs
// such bursts, and s_tready drops only while it is full.
// A token is registered in the bundle queue, then in the sender, before it is shown.
// Reset: scanner idle, offset 0, line 1, queue empty, no output valid.
// When the receiver stalls, the current token holds on the output and
// bytes keep flowing in until the queue fills.
module source_code_tokenizer_top
    import sct_pkg::*;
#(
    parameter int QUEUE_DEPTH = SCT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [23:0] start_offset, [47:24] token_length, [67:48] line_number
    output logic [15:0] m_tuser,   // [6:0] kind, [9:7] error_cause
    output logic        m_tlast
);

    logic    push, full, pop, not_empty;
    bundle_t push_bundle, head;
    tok_t    tok;

    sct_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .ch          (s_tdata),
        .is_end      (s_tlast),
        .q_full      (full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (full),
        .pop         (pop),
        .not_empty   (not_empty),
        .head        (head)
    );

    sct_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (not_empty),
        .q_head      (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_tok     (tok),
        .out_last    (m_tlast)
    );

    // Pack token fields onto the stream
    assign m_tdata = {4'd0, tok.line, tok.len, tok.start};
    assign m_tuser = {6'd0, tok.cause, tok.kind};

endmodule

/* tb/tb.sv */
// Self-checking testbench for source_code_tokenizer_top: a byte stream of keywords,
// operators, literals, comments and noise runs through the block, and every token
// is checked against a behavioral lexer model. Depends on sct_pkg and the RTL.
`timescale 1ns/1ps
module tb;
    import sct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [CAUSE_W-1:0] cause;
        logic [OFF_W-1:0]   start;
        logic [OFF_W-1:0]   len;
        logic [LINE_W-1:0]  line;
        logic               last;
    } token_t;

    typedef struct {
        logic [7:0]         ch;
        logic               is_end;
        bit                 chk;
        logic [KIND_W-1:0]  kind;
        logic [CAUSE_W-1:0] cause;
    } src_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [15:0] m_tuser;
    logic        m_tlast;

    source_code_tokenizer_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Lexer model state
    mode_t              lx_mode;
    logic [OFF_W-1:0]   lx_start;
    logic [OFF_W-1:0]   lx_offset;
    logic [LINE_W-1:0]  lx_line;
    logic [KIND_W-1:0]  lx_prev_kind;
    logic [7:0]         lx_word [8];
    int                 lx_word_len;
    logic [7:0]         lx_prev_byte;
    bit                 lx_done;
    int                 lx_count;

    token_t   expected_tokens [$];
    src_row_t src_rows [$];
    int       mismatches;
    int       bytes_taken;
    int       tokens_seen;
    int       cycles;
    bit       idle_free;

    string keywords [46] = '{
        "v", "c", "r", "i", "e", "f", "w", "l", "m", "b", "s", "as", "fn", "ei", "st",
        "en", "tr", "tp", "in", "u8", "pr", "db", "ret", "any", "async", "await",
        "clone", "else", "eval", "false", "has", "impl", "json", "keys", "mut",
        "match", "nil", "pub", "panic", "recover", "spawn", "sync", "try", "true",
        "typeof", "use"
    };

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit alpha_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void take_byte(logic [7:0] c);
        if (lx_offset != OFF_MAX) lx_offset++;
        if (c == 8'h0a && lx_line != LINE_MAX) lx_line++;
        lx_prev_byte = c;
    endfunction

    function void push_token(logic [KIND_W-1:0] k, logic [CAUSE_W-1:0] cause, bit set_prev);
        token_t t;
        if (lx_count >= TOK_PER_BUNDLE) return;
        t.kind  = k;
        t.cause = cause;
        t.start = lx_start;
        t.len   = lx_offset - lx_start;
        t.line  = lx_line;
        t.last  = 1'b0;
        expected_tokens.push_back(t);
        lx_count++;
        if (set_prev) lx_prev_kind = k;
    endfunction

    function automatic logic [KIND_W-1:0] word_kind();
        bit same;
        if (lx_word_len > KEYWORD_CHARS) return K_IDENT;
        foreach (keywords[i])
        begin
            if (keywords[i].len() == lx_word_len)
            begin
                same = 1;
                for (int j = 0; j < lx_word_len; j++)
                    if (keywords[i][j] != lx_word[j]) same = 0;
                if (same) return K_KW_FIRST + KIND_W'(i);
            end
        end
        return K_IDENT;
    endfunction

    function automatic bit slash_opens_regex();
        logic [KIND_W-1:0] p;
        p = lx_prev_kind;
        return p == K_EQUAL || p == K_LPAREN || p == K_COMMA || p == K_COLON ||
               p == K_BANG || p == K_AMP || p == K_PIPE || p == K_EOF || p == K_MATCH;
    endfunction

    // Single form of a pending operator
    function void single_op();
        case (lx_mode)
            M_QUEST:  push_token(K_QUESTION, CAUSE_NONE, 1);
            M_CARET:  push_token(K_CARET, CAUSE_NONE, 1);
            M_PLUSOP: push_token(K_PLUS, CAUSE_NONE, 1);
            M_BANGOP: push_token(K_BANG, CAUSE_NONE, 1);
            M_EQOP:   push_token(K_EQUAL, CAUSE_NONE, 1);
            M_LTOP:   push_token(K_LESS, CAUSE_NONE, 1);
            M_GTOP:   push_token(K_GREATER, CAUSE_NONE, 1);
            M_AMPOP:  push_token(K_ERROR, CAUSE_LONE_AMP, 1);
            default:  push_token(K_PIPE, CAUSE_NONE, 1);
        endcase
    endfunction

    function void number_and_dot();
        push_token(K_NUMBER, CAUSE_NONE, 1);
        lx_start = lx_offset;
        take_byte(".");
        push_token(K_DOT, CAUSE_NONE, 1);
    endfunction

    function void start_lexeme(logic [7:0] c);
        logic [KIND_W-1:0] k;
        bit hit;
        lx_start = lx_offset;
        take_byte(c);
        if (c == " " || c == 8'h0d || c == 8'h09 || c == 8'h0a) return;
        if (alpha_byte(c))
        begin
            lx_word[0]  = c;
            lx_word_len = 1;
            lx_mode     = M_IDENT;
            return;
        end
        if (digit_byte(c))
        begin
            lx_mode = M_NUM;
            return;
        end
        hit = 1;
        case (c)
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            "[": k = K_LBRACKET;
            "]": k = K_RBRACKET;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            ":": k = K_COLON;
            "@": k = K_AT;
            "#": k = K_HASH;
            ".": k = K_DOT;
            "-": k = K_MINUS;
            "%": k = K_PERCENT;
            "*": k = K_STAR;
            "~": k = K_TILDE;
            default: hit = 0;
        endcase
        if (hit)
        begin
            push_token(k, CAUSE_NONE, 1);
            return;
        end
        case (c)
            "/": lx_mode = M_SLASH;
            "\"": lx_mode = M_STR;
            "?": lx_mode = M_QUEST;
            "^": lx_mode = M_CARET;
            "+": lx_mode = M_PLUSOP;
            "!": lx_mode = M_BANGOP;
            "=": lx_mode = M_EQOP;
            "<": lx_mode = M_LTOP;
            ">": lx_mode = M_GTOP;
            "&": lx_mode = M_AMPOP;
            "|": lx_mode = M_PIPEOP;
            default: push_token(K_ERROR, CAUSE_UNEXPECTED, 0);
        endcase
    endfunction

    // Handle one byte in the current mode; return 1 when it must be seen again
    function automatic bit scan_byte(logic [7:0] c);
        logic [KIND_W-1:0] two;
        bit closes;
        bit paired;
        paired = 0;
        two = K_EOF;
        case (lx_mode)
            M_IDLE:
            begin
                start_lexeme(c);
                return 0;
            end
            M_SLASH:
            begin
                if (c == "/" || c == "*")
                begin
                    take_byte(c);
                    lx_mode = (c == "/") ? M_LCOM : M_BLOCK;
                    return 0;
                end
                if (slash_opens_regex())
                begin
                    lx_mode = M_RE;
                    return 1;
                end
                push_token(K_SLASH, CAUSE_NONE, 1);
                lx_mode = M_IDLE;
                return 1;
            end
            M_LCOM:
            begin
                if (c == 8'h0a)
                begin
                    lx_mode = M_IDLE;
                    return 1;
                end
                take_byte(c);
                return 0;
            end
            M_BLOCK:
            begin
                take_byte(c);
                if (c == "*") lx_mode = M_BSTAR;
                return 0;
            end
            M_BSTAR:
            begin
                take_byte(c);
                if (c == "/") lx_mode = M_IDLE;
                else if (c != "*") lx_mode = M_BLOCK;
                return 0;
            end
            M_IDENT:
            begin
                if (alpha_byte(c) || digit_byte(c))
                begin
                    take_byte(c);
                    if (lx_word_len < KEYWORD_CHARS) lx_word[lx_word_len] = c;
                    if (lx_word_len <= KEYWORD_CHARS) lx_word_len++;
                    return 0;
                end
                push_token(word_kind(), CAUSE_NONE, 1);
                lx_mode = M_IDLE;
                return 1;
            end
            M_NUM:
            begin
                if (digit_byte(c))
                begin
                    take_byte(c);
                    return 0;
                end
                if (c == ".")
                begin
                    lx_mode = M_NUMDOT;
                    return 0;
                end
                push_token(K_NUMBER, CAUSE_NONE, 1);
                lx_mode = M_IDLE;
                return 1;
            end
            M_NUMDOT:
            begin
                if (digit_byte(c))
                begin
                    take_byte(".");
                    take_byte(c);
                    lx_mode = M_FRAC;
                    return 0;
                end
                number_and_dot();
                lx_mode = M_IDLE;
                return 1;
            end
            M_FRAC:
            begin
                if (digit_byte(c))
                begin
                    take_byte(c);
                    return 0;
                end
                push_token(K_NUMBER, CAUSE_NONE, 1);
                lx_mode = M_IDLE;
                return 1;
            end
            M_STR:
            begin
                // a quote right after a backslash never closes
                closes = (c == "\"" && lx_prev_byte != "\\");
                take_byte(c);
                if (closes)
                begin
                    push_token(K_STRING, CAUSE_NONE, 1);
                    lx_mode = M_IDLE;
                end
                return 0;
            end
            M_RE:
            begin
                take_byte(c);
                if (c == "/")
                begin
                    push_token(K_REGEX, CAUSE_NONE, 1);
                    lx_mode = M_IDLE;
                end
                else if (c == "\\") lx_mode = M_REESC;
                return 0;
            end
            M_REESC:
            begin
                take_byte(c);
                lx_mode = M_RE;
                return 0;
            end
            M_QUEST:
            begin
                if (c == "?") begin two = K_QQ; paired = 1; end
                else if (c == ".") begin two = K_QDOT; paired = 1; end
            end
            M_CARET:  if (c == "+") begin two = K_CARET_PLUS; paired = 1; end
            M_PLUSOP: if (c == "~") begin two = K_PLUS_TILDE; paired = 1; end
            M_BANGOP: if (c == "=") begin two = K_BANG_EQ; paired = 1; end
            M_EQOP:   if (c == "=") begin two = K_EQ_EQ; paired = 1; end
            M_LTOP:   if (c == "=") begin two = K_LESS_EQ; paired = 1; end
            M_GTOP:   if (c == "=") begin two = K_GREATER_EQ; paired = 1; end
            M_AMPOP:  if (c == "&") begin two = K_AMP; paired = 1; end
            M_PIPEOP:
            begin
                if (c == ">") begin two = K_PIPE_GT; paired = 1; end
                else if (c == "?") begin two = K_PIPE_Q; paired = 1; end
                else if (c == "|") begin two = K_PIPE; paired = 1; end
            end
            default:
            begin
                lx_mode = M_IDLE;
                return 1;
            end
        endcase
        if (paired)
        begin
            take_byte(c);
            push_token(two, CAUSE_NONE, 1);
            lx_mode = M_IDLE;
            return 0;
        end
        single_op();
        lx_mode = M_IDLE;
        return 1;
    endfunction

    // Flush the pending lexeme and append EOF
    function void finish_text();
        case (lx_mode)
            M_SLASH:
                if (slash_opens_regex()) push_token(K_ERROR, CAUSE_OPEN_RE, 0);
                else push_token(K_SLASH, CAUSE_NONE, 1);
            M_IDENT: push_token(word_kind(), CAUSE_NONE, 1);
            M_NUM, M_FRAC: push_token(K_NUMBER, CAUSE_NONE, 1);
            M_NUMDOT: number_and_dot();
            M_STR: push_token(K_ERROR, CAUSE_OPEN_STR, 0);
            M_RE, M_REESC: push_token(K_ERROR, CAUSE_OPEN_RE, 0);
            M_QUEST, M_CARET, M_PLUSOP, M_BANGOP, M_EQOP, M_LTOP, M_GTOP,
            M_AMPOP, M_PIPEOP: single_op();
            default: ;
        endcase
        lx_mode  = M_IDLE;
        lx_start = lx_offset;
        push_token(K_EOF, CAUSE_NONE, 1);
    endfunction

    // Predict the tokens of one accepted request; return index of its first token
    function automatic int predict_tokens(logic [7:0] c, logic is_end);
        int first;
        first = expected_tokens.size();
        lx_count = 0;
        if (lx_done) return first;
        if (is_end || c == 8'h00)
        begin
            finish_text();
            lx_done = 1;
        end
        else
        begin
            for (int g = 0; g < 4; g++)
                if (!scan_byte(c)) break;
        end
        if (lx_count > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        return first;
    endfunction

    function void report_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, what);
    endfunction

    function void add_row(logic [7:0] c, bit chk = 0, logic [KIND_W-1:0] k = K_EOF,
                          logic [CAUSE_W-1:0] cause = CAUSE_NONE);
        src_row_t r;
        r.ch = c; r.is_end = 1'b0; r.chk = chk; r.kind = k; r.cause = cause;
        src_rows.push_back(r);
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_row(s[i]);
    endfunction

    // Append one random snippet, mostly well-formed source
    function void add_snippet();
        string ops [38] = '{"??", "?.", "^+", "+~", "!=", "==", "<=", ">=", "|>", "|?",
            "||", "&&", "?", "^", "+", "!", "=", "<", ">", "|", "&", "/", "%", "*",
            "-", "~", "@", "#", ".", ",", ":", ";", "(", ")", "{", "}", "[", "]"};
        string s;
        int n;
        case ($urandom_range(0, 11))
            0, 1: add_text(keywords[$urandom_range(0, 45)]);
            2:
            begin
                n = $urandom_range(1, 10);
                s = "";
                for (int i = 0; i < n; i++)
                    s = {s, ($urandom_range(0, 3) == 0) ? "Z_9" : "qx"};
                add_text(s.substr(0, n - 1));
            end
            3: add_text($urandom_range(0, 1) ? "42.75" : "7.");
            4, 5: add_text(ops[$urandom_range(0, 37)]);
            6: add_text($urandom_range(0, 1) ? "\"a\\\"b\"" : "\"x\\\\\"\"");
            7: add_text($urandom_range(0, 1) ? "// note\n" : "/* a ** b */");
            8: add_text($urandom_range(0, 1) ? "=/k\\/z/" : "(/ab/");
            9: add_text($urandom_range(0, 1) ? "\n" : " \t\r");
            default: add_row(8'($urandom_range(1, 255)));
        endcase
    endfunction

    // Source-side gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (idle_free) return 0;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver stalls
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (idle_free)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0: stall_left <= $urandom_range(8, 30);
                1, 2, 3, 4: stall_left <= $urandom_range(0, 3);
                default: stall_left <= 0;
            endcase
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Predict on every accepted request
    int row_idx;
    always @(posedge clk)
    begin
        int first;
        if (rst_n && s_tvalid && s_tready)
        begin
            first = predict_tokens(s_tdata, s_tlast);
            bytes_taken++;
            if (row_idx < src_rows.size() && src_rows[row_idx].chk)
            begin
                if (first >= expected_tokens.size() ||
                    expected_tokens[first].kind != src_rows[row_idx].kind ||
                    expected_tokens[first].cause != src_rows[row_idx].cause)
                    report_mismatch($sformatf("directed row %0d: kind/cause not %0d/%0d",
                                              row_idx, src_rows[row_idx].kind,
                                              src_rows[row_idx].cause));
            end
            row_idx++;
        end
    end

    // Compare every accepted token with the oldest prediction
    always @(posedge clk)
    begin
        token_t t;
        if (rst_n && m_tvalid && m_tready)
        begin
            tokens_seen++;
            if (expected_tokens.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                          m_tuser[6:0], m_tdata[23:0]));
            else
            begin
                t = expected_tokens.pop_front();
                if (m_tuser[6:0] != t.kind || m_tuser[9:7] != t.cause ||
                    m_tdata[23:0] != t.start || m_tdata[47:24] != t.len ||
                    m_tdata[67:48] != t.line || m_tlast != t.last)
                    report_mismatch($sformatf(
                        "exp kind %0d cause %0d start %0d len %0d line %0d last %0b, got %0d %0d %0d %0d %0d %0b",
                        t.kind, t.cause, t.start, t.len, t.line, t.last,
                        m_tuser[6:0], m_tuser[9:7], m_tdata[23:0], m_tdata[47:24],
                        m_tdata[67:48], m_tlast));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int gap;
        bit rdy;
        int wait_cycles;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        mismatches = 0;
        bytes_taken = 0;
        tokens_seen = 0;
        cycles = 0;
        row_idx = 0;
        idle_free = 0;
        lx_mode = M_IDLE;
        lx_start = '0;
        lx_offset = '0;
        lx_line = LINE_W'(1);
        lx_prev_kind = K_EOF;
        lx_word_len = 0;
        lx_prev_byte = 8'h00;
        lx_done = 0;

        // Directed text: regex after paren, escaped slash, double and lone ampersand,
        // unexpected chars, number then dot, escaped quote in a string
        add_row("(", 1, K_LPAREN);
        add_text("/a\\/b");
        add_row("/", 1, K_REGEX);
        add_row("&");
        add_row("&", 1, K_AMP);
        add_row("&");
        add_row("x", 1, K_ERROR, CAUSE_LONE_AMP);
        add_row(" ", 1, K_IDENT);
        add_row("$", 1, K_ERROR, CAUSE_UNEXPECTED);
        add_text("9.");
        add_row("x", 1, K_NUMBER);
        add_text("\"\\\"");
        add_row("\"", 1, K_STRING);
        add_row(8'hff, 1, K_ERROR, CAUSE_UNEXPECTED);

        // Random body, then a zero byte ends the text; later requests are dropped
        while (src_rows.size() < 170) add_snippet();
        add_row(8'h00);
        for (int i = 0; i < 3; i++)
        begin
            src_row_t r;
            r.ch = 8'($urandom_range(0, 255)); r.is_end = 1'b1; r.chk = 0;
            r.kind = K_EOF; r.cause = CAUSE_NONE;
            src_rows.push_back(r);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Send requests, holding each until taken
        foreach (src_rows[i])
        begin
            if (i % 40 == 0) idle_free = ($urandom_range(0, 2) == 0);
            gap = pick_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= src_rows[i].ch;
            s_tlast  <= src_rows[i].is_end;
            do
            begin
                @(negedge clk);
                rdy = s_tready;
                @(posedge clk);
            end
            while (!rdy);
        end
        s_tvalid <= 1'b0;
        idle_free = 0;

        // Drain
        wait_cycles = 0;
        while (expected_tokens.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));

        $display("Sent %0d source bytes (directed and random text, end marker, dropped tail)",
                 bytes_taken);
        $display("Checked %0d tokens, %0d mismatches", tokens_seen, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
